// ===== sv/rangefinder_frame_decoder_defines.svh =====
// Assertion macros for the rangefinder frame decoder checker.
`ifndef RANGEFINDER_FRAME_DECODER_DEFINES_SVH
`define RANGEFINDER_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define RFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define RFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold on the cycle after reset is seen.
`define RFD_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== sv/rfd_pkg.sv =====
// Types, constants and the CRC step for the rangefinder frame decoder.
package rfd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 64;
  localparam int HEAD_DEPTH          = 7;
  localparam int OUT_DATA_W          = 48;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_ERR_CODE = 16'h0005;
  localparam logic [7:0]  FLAG_MASK    = 8'h80;
  localparam logic [7:0]  HEX_HDR0     = 8'hB4;
  localparam logic [7:0]  HEX_HDR1     = 8'h69;
  localparam logic [7:0]  HEX_STOP     = 8'h05;
  localparam int          HEX_LEN      = 8;
  localparam int          MB_MAX_COUNT = 4;
  localparam int          MB_OVERHEAD  = 5;

  localparam logic MODE_MODBUS = 1'b0;
  localparam logic MODE_HEX    = 1'b1;

  localparam logic CFG_PROTOCOL_MODE = 1'b0;
  localparam logic CFG_SLAVE_ADDRESS = 1'b1;

  localparam logic [7:0] SLAVE_ADDRESS_RST = 8'h01;

  typedef enum logic [2:0] {
    ST_DIST   = 3'd0,
    ST_EXC    = 3'd1,
    ST_FAULT  = 3'd2,
    ST_CHECK  = 3'd3,
    ST_STOP   = 3'd4,
    ST_REJECT = 3'd5
  } status_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] rx_byte;
  } beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] distance_mm;
    logic [15:0] error_code;
  } result_t;

  // One byte of the reflected CRC-16, eight shift steps.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/rangefinder_frame_decoder.sv =====
// One result beat per frame; its frame end goes through the input, then the result register.
// Throughput: one input beat per cycle barring a frame-end stall, set by the single-pass
//   decode between two registers; the per-byte CRC step and XOR sit in that pass.
// A frame-end beat waits in the input register while the result register is full.
// Reset (rst, synchronous): clears handshake state, frame state and config.
module rangefinder_frame_decoder #(
  parameter int MAX_FRAME_BYTES = rfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic                           cfg_index,  // 0 protocol_mode, 1 slave_address
  input  logic [7:0]                     cfg_data,
  // received bytes
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,    // [7:0] rx_byte
  input  logic                           s_tlast,    // frame_end
  // frame results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rfd_pkg::OUT_DATA_W-1:0] m_tdata,    // [31:0] distance_mm, [47:32] error_code
  output logic [2:0]                     m_tuser     // [2:0] status
);
  import rfd_pkg::*;

  logic    slot_free;
  logic    advance;
  beat_t   beat;
  logic    res_valid;
  result_t res;

  // Hold the incoming beat; release it when the core may consume it.
  rfd_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .slot_free (slot_free),
    .advance   (advance),
    .beat      (beat)
  );

  // Update the running CRC, XOR, header bytes and distance; decode at frame end.
  rfd_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the result beat for the sink; bytes other than a frame end keep flowing meanwhile.
  rfd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== sv/rfd_in_reg.sv =====
// Input register stage: holds one beat and hands it to the decode core.
module rfd_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] rx_byte
  input  logic          s_tlast,   // frame_end
  input  logic          slot_free,
  output logic          advance,
  output rfd_pkg::beat_t beat
);
  import rfd_pkg::*;

  logic  held;
  beat_t held_beat;

  // A frame-end beat waits for room in the result register; others never wait.
  assign advance  = held && (!held_beat.frame_end || slot_free);
  assign s_tready = !held || advance;
  assign beat     = held_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_beat.rx_byte   <= s_tdata;
      held_beat.frame_end <= s_tlast;
    end
  end

endmodule

// ===== sv/rfd_core.sv =====
// Frame state, running checks and the frame-end decode.
module rfd_core #(
  parameter int MAX_FRAME_BYTES = rfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             advance,
  input  rfd_pkg::beat_t   beat,
  output logic             res_valid,
  output rfd_pkg::result_t res
);
  import rfd_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

  logic             protocol_mode;
  logic [7:0]       slave_address;

  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [15:0]      crc_acc, crc_acc_next;
  logic [7:0]       xor_acc, xor_acc_next;
  logic [15:0]      tail_bytes, tail_bytes_next;
  logic [31:0]      value_acc, value_acc_next;
  logic             overflow_flag, overflow_flag_next;
  logic [7:0]       head_bytes [HEAD_DEPTH];
  logic [7:0]       head_v [HEAD_DEPTH];

  logic             in_range;
  logic [IDX_W-1:0] len;
  logic             crc_ok;
  logic [7:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode <= MODE_MODBUS;
      slave_address <= SLAVE_ADDRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROTOCOL_MODE: protocol_mode <= cfg_data[0];
        CFG_SLAVE_ADDRESS: slave_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_range        = byte_index < IDX_W'(MAX_FRAME_BYTES);
    crc_acc_next    = (byte_index >= IDX_W'(2)) ? crc_feed(crc_acc, tail_bytes[15:8]) : crc_acc;
    tail_bytes_next = {tail_bytes[7:0], beat.rx_byte};
    xor_acc_next    = xor_acc ^ beat.rx_byte;
    overflow_flag_next = overflow_flag || !in_range;
    byte_index_next = in_range ? byte_index + IDX_W'(1) : byte_index;
    value_acc_next  = value_acc;
    // Count byte is already stored once the data bytes start.
    if (in_range && byte_index >= IDX_W'(3) && head_bytes[2] <= 8'(MB_MAX_COUNT) &&
        byte_index < IDX_W'(3) + IDX_W'(head_bytes[2][2:0])) begin
      value_acc_next = {value_acc[23:0], beat.rx_byte};
    end
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_v[i] = (byte_index == IDX_W'(i)) ? beat.rx_byte : head_bytes[i];
    end
  end

  assign len    = byte_index + IDX_W'(1);
  assign crc_ok = (crc_acc_next[7:0] == tail_bytes_next[15:8]) &&
                  (crc_acc_next[15:8] == tail_bytes_next[7:0]);
  assign count  = head_v[2];

  always_comb begin
    res.status      = ST_REJECT;
    res.distance_mm = '0;
    res.error_code  = '0;
    if (overflow_flag_next) begin
      res.status = ST_REJECT;
    end else if (protocol_mode == MODE_MODBUS) begin
      if (head_v[0] != slave_address || len < IDX_W'(3)) begin
        res.status = ST_REJECT;
      end else if ((head_v[1] & FLAG_MASK) != 8'h00) begin
        res.status     = ST_EXC;
        res.error_code = {8'h00, head_v[2]};
      end else if (len >= IDX_W'(4) && (head_v[3] & FLAG_MASK) != 8'h00) begin
        if (len >= IDX_W'(7)) begin
          res.status     = ST_FAULT;
          res.error_code = {head_v[5], head_v[6]};
        end else begin
          res.status = ST_REJECT;
        end
      end else if (len < IDX_W'(MB_OVERHEAD)) begin
        res.status = ST_REJECT;
      end else if (!crc_ok) begin
        res.status     = ST_CHECK;
        res.error_code = CRC_ERR_CODE;
      end else if (count > 8'(MB_MAX_COUNT) ||
                   len != IDX_W'(count[2:0]) + IDX_W'(MB_OVERHEAD)) begin
        res.status = ST_REJECT;
      end else begin
        res.status      = ST_DIST;
        res.distance_mm = value_acc_next;
      end
    end else begin
      if (len != IDX_W'(HEX_LEN) || head_v[0] != HEX_HDR0 || head_v[1] != HEX_HDR1) begin
        res.status = ST_REJECT;
      end else if ((head_v[2] & FLAG_MASK) != 8'h00) begin
        res.status     = ST_FAULT;
        res.error_code = {head_v[2], head_v[3]};
      end else if (xor_acc_next != 8'h00) begin
        res.status = ST_CHECK;
      end else if (head_v[2] == HEX_STOP) begin
        res.status = ST_STOP;
      end else begin
        res.status      = ST_DIST;
        res.distance_mm = {head_v[3], head_v[4], head_v[5], head_v[6]};
      end
    end
  end

  assign res_valid = advance && beat.frame_end;

  // Advance the frame state; drop back to the idle values after a frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      crc_acc       <= CRC_INIT;
      xor_acc       <= '0;
      tail_bytes    <= '0;
      value_acc     <= '0;
      overflow_flag <= 1'b0;
    end else if (advance) begin
      if (beat.frame_end) begin
        byte_index    <= '0;
        crc_acc       <= CRC_INIT;
        xor_acc       <= '0;
        tail_bytes    <= '0;
        value_acc     <= '0;
        overflow_flag <= 1'b0;
      end else begin
        byte_index    <= byte_index_next;
        crc_acc       <= crc_acc_next;
        xor_acc       <= xor_acc_next;
        tail_bytes    <= tail_bytes_next;
        value_acc     <= value_acc_next;
        overflow_flag <= overflow_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && byte_index < IDX_W'(HEAD_DEPTH)) begin
      head_bytes[byte_index[2:0]] <= beat.rx_byte;
    end
  end

endmodule

// ===== sv/rfd_out_reg.sv =====
// Result register: holds one decoded frame result until the sink takes it.
module rfd_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           res_valid,
  input  rfd_pkg::result_t               res,
  output logic                           slot_free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rfd_pkg::OUT_DATA_W-1:0] m_tdata,  // [31:0] distance_mm, [47:32] error_code
  output logic [2:0]                     m_tuser   // [2:0] status
);
  import rfd_pkg::*;

  result_t held;

  assign slot_free = !m_tvalid || m_tready;
  assign m_tdata   = {held.error_code, held.distance_mm};
  assign m_tuser   = held.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

endmodule

// ===== sv/rfd_checker.sv =====
// Port-level checks for the rangefinder frame decoder, bound to the top level.
`include "rangefinder_frame_decoder_defines.svh"

module rfd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rfd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [2:0]                     m_tuser
);
  import rfd_pkg::*;

  `RFD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")
  `RFD_ASSERT_RST(a_rst_empty, !m_tvalid, "result beat present right after reset")
  `RFD_ASSERT_IMP(a_dist_zero, m_tvalid && m_tuser != ST_DIST, m_tdata[31:0] == 32'h0, "distance set on a non-distance result")
  `RFD_ASSERT_IMP(a_code_zero, m_tvalid && (m_tuser == ST_DIST || m_tuser == ST_STOP || m_tuser == ST_REJECT), m_tdata[47:32] == 16'h0, "error code set on a result that carries none")

endmodule

bind rangefinder_frame_decoder rfd_checker u_rfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
